>>> rtl/ille_pkg.sv
// Package for the indexed linked list engine: sizes, codes and transaction types.
// No dependencies.
package ille_pkg;

	localparam int NODE_COUNT = 256;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int LEN_W      = $clog2(NODE_COUNT + 1);
	localparam int VAL_W      = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_FIND   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ROTATE,
		CELL_INSERT,
		CELL_DELETE
	} cell_op_t;

	typedef struct packed {
		kind_t                    kind;
		logic [8:0]               position;
		logic signed [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic [7:0]               found_position;
		logic signed [VAL_W-1:0]  read_value;
		logic [8:0]               list_length;
	} rsp_t;

	typedef struct packed {
		cell_op_t                 op;
		logic [8:0]               position;
		logic [VAL_W-1:0]         data;
	} cell_ctrl_t;

endpackage

>>> rtl/ille_cell.sv
// One list cell: holds the entry at its position and shifts with its neighbors.
// Depends on ille_pkg.
module ille_cell (
	input  logic                         clk,
	input  ille_pkg::cell_ctrl_t         ctrl,
	input  logic [ille_pkg::IDX_W-1:0]   idx,
	input  logic [ille_pkg::VAL_W-1:0]   left_val,
	input  logic [ille_pkg::VAL_W-1:0]   right_val,
	output logic [ille_pkg::VAL_W-1:0]   val
);
	logic [ille_pkg::VAL_W-1:0] val_q;
	logic [8:0] my_pos;

	assign my_pos = {1'b0, idx};
	assign val = val_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ille_pkg::CELL_ROTATE: val_q <= right_val;
			ille_pkg::CELL_INSERT: begin
				if (my_pos == ctrl.position) val_q <= ctrl.data;
				else if (my_pos > ctrl.position) val_q <= left_val;
			end
			ille_pkg::CELL_DELETE: begin
				if (my_pos >= ctrl.position) val_q <= right_val;
			end
			default: val_q <= val_q;
		endcase
	end
endmodule

>>> rtl/ille_ctrl.sv
// Sequencer: rotates the cell chain once per request, then applies the update.
// Depends on ille_pkg.
module ille_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  ille_pkg::req_t              req,
	input  logic [ille_pkg::VAL_W-1:0]  head_val,
	output ille_pkg::cell_ctrl_t        cell_ctrl,
	output logic                        busy,
	output logic                        done,
	output ille_pkg::rsp_t              rsp
);
	ille_pkg::fsm_t state_q, state_d;
	logic [ille_pkg::IDX_W-1:0] step_q;
	logic [8:0] count_q, count_d;
	ille_pkg::req_t req_q;
	logic found_q;
	logic [7:0] fpos_q;
	logic [ille_pkg::VAL_W-1:0] rd_q;
	logic done_q, done_d;
	ille_pkg::rsp_t rsp_q, rsp_d;
	logic in_list;

	assign busy = (state_q != ille_pkg::FSM_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;
	assign in_list = ({1'b0, step_q} < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ille_pkg::FSM_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (state_q == ille_pkg::FSM_IDLE) begin
			req_q   <= req;
			step_q  <= '0;
			found_q <= 1'b0;
			fpos_q  <= '0;
			rd_q    <= '0;
		end else if (state_q == ille_pkg::FSM_SCAN) begin
			step_q <= step_q + 1'b1;
			if (in_list && !found_q && head_val == req_q.value) begin
				found_q <= 1'b1;
				fpos_q  <= 8'(step_q);
			end
			if ({1'b0, step_q} == req_q.position) rd_q <= head_val;
		end
	end

	always_comb begin
		state_d            = state_q;
		count_d            = count_q;
		done_d             = 1'b0;
		rsp_d              = rsp_q;
		cell_ctrl.op       = ille_pkg::CELL_HOLD;
		cell_ctrl.position = req_q.position;
		cell_ctrl.data     = req_q.value;
		case (state_q)
			ille_pkg::FSM_IDLE: begin
				if (start) state_d = ille_pkg::FSM_SCAN;
			end
			ille_pkg::FSM_SCAN: begin
				cell_ctrl.op = ille_pkg::CELL_ROTATE;
				if (step_q == ille_pkg::IDX_W'(ille_pkg::NODE_COUNT - 1))
					state_d = ille_pkg::FSM_FINISH;
			end
			ille_pkg::FSM_FINISH: begin
				state_d = ille_pkg::FSM_IDLE;
				done_d  = 1'b1;
				rsp_d.status         = ille_pkg::ST_OK;
				rsp_d.found_position = '0;
				rsp_d.read_value     = '0;
				case (req_q.kind)
					ille_pkg::KIND_INSERT: begin
						if (req_q.position > count_q)
							rsp_d.status = ille_pkg::ST_RANGE;
						else if (count_q == 9'(ille_pkg::NODE_COUNT))
							rsp_d.status = ille_pkg::ST_FULL;
						else begin
							cell_ctrl.op = ille_pkg::CELL_INSERT;
							count_d = count_q + 1'b1;
						end
					end
					ille_pkg::KIND_DELETE: begin
						if (req_q.position >= count_q)
							rsp_d.status = ille_pkg::ST_RANGE;
						else begin
							cell_ctrl.op = ille_pkg::CELL_DELETE;
							count_d = count_q - 1'b1;
							rsp_d.read_value = rd_q;
						end
					end
					ille_pkg::KIND_FIND: begin
						if (found_q) rsp_d.found_position = fpos_q;
						else rsp_d.status = ille_pkg::ST_NOT_FOUND;
					end
					default: begin
						if (req_q.position >= count_q) rsp_d.status = ille_pkg::ST_RANGE;
						else rsp_d.read_value = rd_q;
					end
				endcase
				rsp_d.list_length = count_d;
			end
			default: state_d = ille_pkg::FSM_IDLE;
		endcase
	end
endmodule

>>> rtl/indexed_linked_list_engine_top.sv
// Top level of the indexed linked list engine: sequencer plus a ring of list cells.
// Depends on ille_pkg, ille_cell, ille_ctrl.
//
//  channel  | handshake          | payload
//  request  | start, busy        | req (kind, position, value)
//  result   | done (one cycle)   | rsp (status, found_position, read_value, list_length)
//
// For every request the cell ring rotates once past cell 0 to walk the list, then the
// FINISH state applies the update and done follows, registered.
// busy is high from the cycle after accept until done; a new start is taken with done.
// Reset empties the list at once. Results cannot be stalled.
module indexed_linked_list_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ille_pkg::req_t    req,
	output logic              busy,
	output logic              done,
	output ille_pkg::rsp_t    rsp
);
	ille_pkg::cell_ctrl_t cell_ctrl;
	logic [ille_pkg::VAL_W-1:0] vals [ille_pkg::NODE_COUNT];

	ille_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .head_val(vals[0]),
		.cell_ctrl(cell_ctrl), .busy(busy), .done(done), .rsp(rsp)
	);

	for (genvar i = 0; i < ille_pkg::NODE_COUNT; i++) begin : g_cell
		ille_cell u_cell (
			.clk(clk), .ctrl(cell_ctrl), .idx(ille_pkg::IDX_W'(i)),
			.left_val(vals[(i + ille_pkg::NODE_COUNT - 1) % ille_pkg::NODE_COUNT]),
			.right_val(vals[(i + 1) % ille_pkg::NODE_COUNT]),
			.val(vals[i])
		);
	end
endmodule

>>> rtl/ille_checker.sv
// Port-level checks for the indexed linked list engine, bound to the top level.
// Depends on ille_pkg and indexed_linked_list_engine_top.
module ille_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input ille_pkg::rsp_t  rsp
);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held two cycles");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.list_length <= 9'(ille_pkg::NODE_COUNT))) else $error("length range");
	a_find_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ille_pkg::ST_OK) |-> (rsp.found_position == 8'd0))
		else $error("position on failed request");
endmodule

bind indexed_linked_list_engine_top ille_checker u_ille_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
